// ===== sv/pbf_pkg.sv =====
package pbf_pkg;

  localparam int CapW  = 25;
  localparam int SizeW = 11;
  localparam int ToffW = 10;

  typedef enum logic [1:0] {
    KIND_CHUNK = 2'd0,
    KIND_EMIT  = 2'd1,
    KIND_BADP  = 2'd2,
    KIND_BIG   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_SPLIT    = 2'd1,
    REG_OFFSET   = 2'd2,
    REG_COUNT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] raw_partition;
    logic [10:0] tuple_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  partition;
    logic [24:0] buffer_offset;
    logic [10:0] chunk_length;
    logic [9:0]  tuple_offset;
    logic [31:0] tuples_total;
    logic [63:0] bytes_total;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FLUSH = 2'd1,
    OP_BADP  = 2'd2,
    OP_BIG   = 2'd3
  } cmd_op_t;

  // classified command from front to back
  typedef struct packed {
    cmd_op_t     op;
    logic [4:0]  part;
    logic [10:0] size;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PLACE,
    ST_FLUSH,
    ST_OUT
  } st_t;

endpackage

// ===== sv/partitioned_buffer_filler_core.sv =====
// Partitioned buffer filler.
// Input channel (in_valid/in_ready/in_data): write beats (partition, size)
// or flush beats. Output channel (out_valid/out_ready/out_data): result
// beats; last marks the final beat of an input item. A flush with nothing
// open gives no beat.
// Config: cfg_we/cfg_index/cfg_data, write only, while idle.
// A two-entry command queue sits between the classifying front end and the
// placement sequencer, so the input takes up to two more beats while results
// stall.
// An error beat passes through the command queue to the output register;
// the first beat of a write passes through the queue, prepare and place
// steps. The sequencer takes the next command only once the output
// register is empty. A flush walks all NUM_PARTITIONS fill counters, one
// per cycle while the output register can advance.
// The sequencer advances only when the output register is free, so a
// stalled receiver holds everything upstream with no loss.
// Reset: all buffers closed, totals zero, registers at defaults.
module partitioned_buffer_filler_core #(
  parameter int NUM_PARTITIONS = 32,
  parameter int MAX_TUPLE      = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbf_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic [24:0] buffer_capacity, cap;
  logic split_mode;
  logic [31:0] partition_offset;
  logic [5:0] partition_count;
  logic cmd_valid, cmd_ready;
  pbf_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity  <= 25'd65536;
      split_mode       <= 1'b1;
      partition_offset <= '0;
      partition_count  <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        pbf_pkg::REG_CAPACITY: buffer_capacity  <= cfg_data[24:0];
        pbf_pkg::REG_SPLIT:    split_mode       <= cfg_data[0];
        pbf_pkg::REG_OFFSET:   partition_offset <= cfg_data;
        pbf_pkg::REG_COUNT:    partition_count  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign cap = (buffer_capacity < 25'd64) ? 25'd64 :
               (buffer_capacity > 25'd16777216) ? 25'd16777216 : buffer_capacity;

  pbf_front #(.NUM_PARTITIONS(NUM_PARTITIONS), .MAX_TUPLE(MAX_TUPLE)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .partition_offset,
    .partition_count, .split_mode, .cap, .cmd_valid, .cmd_ready, .cmd
  );

  pbf_back #(.NUM_PARTITIONS(NUM_PARTITIONS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .split_mode, .cap,
    .out_valid, .out_ready, .out_data
  );
endmodule

// ===== sv/pbf_front.sv =====
module pbf_front #(
  parameter int NUM_PARTITIONS = 32,
  parameter int MAX_TUPLE      = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pbf_pkg::in_item_t in_data,
  input  logic [31:0]      partition_offset,
  input  logic [5:0]       partition_count,
  input  logic             split_mode,
  input  logic [24:0]      cap,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output pbf_pkg::cmd_t    cmd
);
  localparam int QD = 2;
  localparam logic [5:0] NP = 6'(NUM_PARTITIONS);
  localparam logic [10:0] MT = 11'(MAX_TUPLE);

  pbf_pkg::cmd_t q [QD];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  pbf_pkg::cmd_t c;
  logic [31:0] local_idx;
  logic [5:0] eff_cnt;
  logic push, pop;

  assign eff_cnt   = (partition_count < NP) ? partition_count : NP;
  assign local_idx = in_data.raw_partition - partition_offset;
  assign in_ready  = (cnt != 2'(QD));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rp];

  always_comb begin
    c.part = local_idx[4:0];
    c.size = in_data.tuple_size;
    if (in_data.operation) begin
      c.op = pbf_pkg::OP_FLUSH;
    end else if (local_idx >= {26'd0, eff_cnt}) begin
      c.op = pbf_pkg::OP_BADP;
    end else if (in_data.tuple_size > MT ||
                 (!split_mode && {14'd0, in_data.tuple_size} > cap)) begin
      c.op = pbf_pkg::OP_BIG;
    end else begin
      c.op = pbf_pkg::OP_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= c;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== sv/pbf_back.sv =====
module pbf_back #(
  parameter int NUM_PARTITIONS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pbf_pkg::cmd_t      cmd,
  input  logic               split_mode,
  input  logic [24:0]        cap,
  output logic               out_valid,
  input  logic               out_ready,
  output pbf_pkg::out_item_t out_data
);
  localparam int PW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam logic [PW:0] NP = (PW+1)'(NUM_PARTITIONS);

  pbf_pkg::st_t st, st_next;
  logic [24:0] fill_mem [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] open_bits, open_bits_next;
  pbf_pkg::cmd_t cur, cur_next;
  logic [24:0] fill, fill_next;
  logic [10:0] done, done_next;
  logic spill, spill_next;
  logic [PW:0] scan, scan_next;
  logic [31:0] tuple_count, tuple_count_next;
  logic [63:0] byte_count, byte_count_next;
  pbf_pkg::out_item_t ob, ob_next;
  logic ob_valid, ob_valid_next;
  logic [PW-1:0] pidx, sidx;
  logic [24:0] room, need, chunk, fill_sum;
  logic [10:0] done_sum;
  logic [25:0] sum;
  logic [24:0] rd;
  logic adv, do_emit, do_whole, fin, closes, later;
  logic mem_we;
  logic [24:0] mem_wd;

  assign pidx      = cur.part[PW-1:0];
  assign sidx      = scan[PW-1:0];
  assign out_valid = ob_valid;
  assign out_data  = ob;
  assign cmd_ready = (st == pbf_pkg::ST_IDLE) && !ob_valid;
  assign adv       = !ob_valid || out_ready;
  assign room      = cap - fill;
  assign need      = {14'd0, cur.size - done};
  assign chunk     = (room < need) ? room : need;
  assign fill_sum  = fill + chunk;
  assign done_sum  = done + chunk[10:0];
  assign fin       = (done_sum == cur.size);
  assign closes    = (fill_sum == cap);
  assign sum       = {1'b0, fill} + {14'd0, cur.size};
  assign rd        = fill_mem[sidx];
  assign do_emit   = (fill > cap) || (!split_mode && sum > {1'b0, cap}) ||
                     (split_mode && done != cur.size && fill == cap);
  assign do_whole  = (sum <= {1'b0, cap}) && !spill;

  // any nonempty open buffer past the scan point
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < NUM_PARTITIONS; i++) begin
      if ((PW+1)'(i) > scan && open_bits[i] && fill_mem[i] != '0) later = 1'b1;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      pbf_pkg::ST_IDLE: if (cmd_valid && cmd_ready) begin
        case (cmd.op)
          pbf_pkg::OP_WRITE: st_next = pbf_pkg::ST_PREP;
          pbf_pkg::OP_FLUSH: st_next = pbf_pkg::ST_FLUSH;
          default:           st_next = pbf_pkg::ST_IDLE;
        endcase
      end
      pbf_pkg::ST_PREP: st_next = pbf_pkg::ST_PLACE;
      pbf_pkg::ST_PLACE: if (adv) begin
        if (do_emit) begin
          st_next = pbf_pkg::ST_PLACE;
        end else if (do_whole) begin
          st_next = pbf_pkg::ST_IDLE;
        end else if (fin) begin
          st_next = closes ? pbf_pkg::ST_OUT : pbf_pkg::ST_IDLE;
        end
      end
      pbf_pkg::ST_OUT: if (adv) st_next = pbf_pkg::ST_IDLE;
      pbf_pkg::ST_FLUSH: if (adv && scan == NP) st_next = pbf_pkg::ST_IDLE;
      default: st_next = pbf_pkg::ST_IDLE;
    endcase
  end

  // each step emits at most one beat
  always_comb begin
    cur_next         = cur;
    fill_next        = fill;
    done_next        = done;
    spill_next       = spill;
    scan_next        = scan;
    tuple_count_next = tuple_count;
    byte_count_next  = byte_count;
    open_bits_next   = open_bits;
    ob_next          = ob;
    ob_valid_next    = ob_valid && !out_ready;
    mem_we           = 1'b0;
    mem_wd           = fill;
    case (st)
      pbf_pkg::ST_IDLE: if (cmd_valid && cmd_ready) begin
        cur_next   = cmd;
        done_next  = '0;
        spill_next = 1'b0;
        scan_next  = '0;
        if (cmd.op == pbf_pkg::OP_BADP || cmd.op == pbf_pkg::OP_BIG) begin
          ob_next = '{kind: (cmd.op == pbf_pkg::OP_BADP) ? pbf_pkg::KIND_BADP
                                                          : pbf_pkg::KIND_BIG,
                      partition: cmd.part, buffer_offset: '0, chunk_length: '0,
                      tuple_offset: '0, tuples_total: tuple_count,
                      bytes_total: byte_count, last: 1'b1};
          ob_valid_next = 1'b1;
        end
      end
      pbf_pkg::ST_PREP: begin
        tuple_count_next     = tuple_count + 32'd1;
        byte_count_next      = byte_count + {53'd0, cur.size};
        fill_next            = open_bits[pidx] ? fill_mem[pidx] : '0;
        open_bits_next[pidx] = 1'b1;
      end
      pbf_pkg::ST_PLACE: if (adv) begin
        ob_next = '{kind: pbf_pkg::KIND_CHUNK, partition: cur.part,
                    buffer_offset: fill, chunk_length: '0, tuple_offset: '0,
                    tuples_total: tuple_count, bytes_total: byte_count,
                    last: 1'b0};
        ob_valid_next = 1'b1;
        mem_we = 1'b1;
        if (do_emit) begin
          ob_next.kind = pbf_pkg::KIND_EMIT;
          fill_next = '0;
          mem_wd = '0;
          if (split_mode && fill == cap) spill_next = 1'b1;
        end else if (do_whole) begin
          ob_next.chunk_length = cur.size;
          ob_next.last = 1'b1;
          fill_next = sum[24:0];
          mem_wd = sum[24:0];
        end else begin
          ob_next.chunk_length = chunk[10:0];
          ob_next.tuple_offset = done[9:0];
          ob_next.last = fin && !closes;
          fill_next = fill_sum;
          mem_wd = fill_sum;
          done_next = done_sum;
          spill_next = 1'b1;
        end
      end
      pbf_pkg::ST_OUT: if (adv) begin
        ob_next = '{kind: pbf_pkg::KIND_EMIT, partition: cur.part,
                    buffer_offset: fill, chunk_length: '0, tuple_offset: '0,
                    tuples_total: tuple_count, bytes_total: byte_count,
                    last: 1'b1};
        ob_valid_next = 1'b1;
        fill_next = '0;
        mem_we = 1'b1;
        mem_wd = '0;
      end
      pbf_pkg::ST_FLUSH: if (adv && scan != NP) begin
        if (open_bits[sidx] && rd != '0) begin
          ob_next = '{kind: pbf_pkg::KIND_EMIT, partition: 5'(scan),
                      buffer_offset: rd, chunk_length: '0, tuple_offset: '0,
                      tuples_total: tuple_count, bytes_total: byte_count,
                      last: !later};
          ob_valid_next = 1'b1;
        end
        open_bits_next[sidx] = 1'b0;
        scan_next = scan + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we && !rst) begin
      fill_mem[pidx] <= mem_wd;
    end
    if (rst) begin
      st          <= pbf_pkg::ST_IDLE;
      cur         <= '0;
      fill        <= '0;
      done        <= '0;
      spill       <= 1'b0;
      scan        <= '0;
      tuple_count <= '0;
      byte_count  <= '0;
      open_bits   <= '0;
      ob          <= '0;
      ob_valid    <= 1'b0;
    end else begin
      st          <= st_next;
      cur         <= cur_next;
      fill        <= fill_next;
      done        <= done_next;
      spill       <= spill_next;
      scan        <= scan_next;
      tuple_count <= tuple_count_next;
      byte_count  <= byte_count_next;
      open_bits   <= open_bits_next;
      ob          <= ob_next;
      ob_valid    <= ob_valid_next;
    end
  end
endmodule

// ===== sv/pbf_checker.sv =====
module pbf_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input pbf_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat dropped or changed");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == pbf_pkg::KIND_BADP ||
                  out_data.kind == pbf_pkg::KIND_BIG) |-> out_data.last)
    else $error("error beat not last");
  a_chunk_fit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == pbf_pkg::KIND_CHUNK |->
      out_data.chunk_length <= 11'd1024)
    else $error("chunk too long");
endmodule

bind partitioned_buffer_filler_core pbf_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_data
);

// ===== tb/tb_partitioned_buffer_filler_core.sv =====
module tb_partitioned_buffer_filler_core;

  localparam int NPART = 32;
  localparam int MAXT = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  pbf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  pbf_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  partitioned_buffer_filler_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow registers and buffer state
  logic [24:0] m_cap;
  logic m_split;
  logic [31:0] m_offset;
  logic [5:0] m_count;
  logic [31:0] m_fill [NPART];
  logic m_open [NPART];
  logic [31:0] m_tuples;
  logic [63:0] m_bytes;

  pbf_pkg::in_item_t pend_q [$];
  pbf_pkg::out_item_t placement_q [$];
  int tx_idle = 0;
  int rx_idle = 0;
  bit in_took = 0;
  int errs = 0;
  int cycles = 0;

  function automatic void add_res(pbf_pkg::kind_t k, int unsigned p, int unsigned boff,
                                  int unsigned clen, int unsigned toff);
    pbf_pkg::out_item_t r;
    r.kind = k;
    r.partition = p[4:0];
    r.buffer_offset = boff[24:0];
    r.chunk_length = clen[10:0];
    r.tuple_offset = toff[9:0];
    r.tuples_total = m_tuples;
    r.bytes_total = m_bytes;
    r.last = 1'b0;
    placement_q = {placement_q, r};
  endfunction

  function automatic void pend_add(pbf_pkg::in_item_t it);
    pend_q = {pend_q, it};
  endfunction

  function automatic void close_buf(int unsigned p);
    add_res(pbf_pkg::KIND_EMIT, p, m_fill[p], 0, 0);
    m_fill[p] = 0;
    m_open[p] = 1;
  endfunction

  function automatic void place_tuple(pbf_pkg::in_item_t it);
    int unsigned cap, cnt, loc, sz, fl, done, ch;
    int before_n;
    before_n = placement_q.size();
    cap = (m_cap < 64) ? 64 : (m_cap > 25'h1000000) ? 32'h1000000 : 32'(m_cap);
    cnt = (m_count < NPART) ? 32'(m_count) : NPART;
    sz = 32'(it.tuple_size);
    if (it.operation) begin
      for (int p = 0; p < NPART; p++) begin
        if (m_open[p] && m_fill[p] > 0) add_res(pbf_pkg::KIND_EMIT, p, m_fill[p], 0, 0);
        m_open[p] = 0;
        m_fill[p] = 0;
      end
    end else begin
      loc = it.raw_partition - m_offset;
      if (loc >= cnt) begin
        add_res(pbf_pkg::KIND_BADP, loc, 0, 0, 0);
      end else if (sz > MAXT || (!m_split && sz > cap)) begin
        add_res(pbf_pkg::KIND_BIG, loc, 0, 0, 0);
      end else begin
        m_tuples = m_tuples + 32'd1;
        m_bytes = m_bytes + 64'(sz);
        if (!m_open[loc]) begin
          m_open[loc] = 1;
          m_fill[loc] = 0;
        end
        if (m_fill[loc] > cap) close_buf(loc);
        fl = m_fill[loc];
        if (fl + sz <= cap) begin
          add_res(pbf_pkg::KIND_CHUNK, loc, fl, sz, 0);
          m_fill[loc] = fl + sz;
        end else if (m_split) begin
          done = 0;
          do begin
            fl = m_fill[loc];
            ch = sz - done;
            if (cap - fl < ch) ch = cap - fl;
            if (ch > 0) add_res(pbf_pkg::KIND_CHUNK, loc, fl, ch, done);
            done += ch;
            m_fill[loc] = fl + ch;
            if (m_fill[loc] == cap) close_buf(loc);
          end while (done < sz);
        end else begin
          close_buf(loc);
          add_res(pbf_pkg::KIND_CHUNK, loc, 0, sz, 0);
          m_fill[loc] = sz;
        end
      end
    end
    if (placement_q.size() > before_n) placement_q[$].last = 1'b1;
  endfunction

  initial forever #4 clk = ~clk;

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
      out_ready <= 0;
    end else begin
      if (!in_valid || in_took) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
          in_data <= pend_q.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    pbf_pkg::out_item_t e;
    cycles <= cycles + 1;
    in_took = !rst && in_valid && in_ready;
    if (in_took) place_tuple(in_data);
    if (!rst && out_valid && out_ready) begin
      if (placement_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected beat %p", out_data);
      end else begin
        e = placement_q.pop_front();
        if (out_data.kind !== e.kind || out_data.partition !== e.partition ||
            out_data.buffer_offset !== e.buffer_offset ||
            out_data.chunk_length !== e.chunk_length ||
            out_data.tuple_offset !== e.tuple_offset ||
            out_data.tuples_total !== e.tuples_total ||
            out_data.bytes_total !== e.bytes_total || out_data.last !== e.last) begin
          errs++;
          if (errs <= 10) $display("mismatch exp %p got %p", e, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic set_reg(pbf_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pbf_pkg::REG_CAPACITY: m_cap = val[24:0];
      pbf_pkg::REG_SPLIT:    m_split = val[0];
      pbf_pkg::REG_OFFSET:   m_offset = val;
      pbf_pkg::REG_COUNT:    m_count = val[5:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] cap, logic sp, logic [31:0] off, logic [31:0] cnt);
    set_reg(pbf_pkg::REG_CAPACITY, cap);
    set_reg(pbf_pkg::REG_SPLIT, {31'd0, sp});
    set_reg(pbf_pkg::REG_OFFSET, off);
    set_reg(pbf_pkg::REG_COUNT, cnt);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pend_q.size() > 0 || in_valid || placement_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic pbf_pkg::in_item_t item(logic op, logic [31:0] raw, logic [10:0] sz);
    pbf_pkg::in_item_t it;
    it.operation = op;
    it.raw_partition = raw;
    it.tuple_size = sz;
    return it;
  endfunction

  task automatic add_random(int n);
    int unsigned cnt, r;
    logic [10:0] sz;
    logic [31:0] raw;
    cnt = (m_count < NPART) ? 32'(m_count) : NPART;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 60) sz = 11'($urandom_range(0, 80));
      else if (r < 85) sz = 11'($urandom_range(81, 1024));
      else if (r < 95) sz = 11'($urandom_range(1025, 2047));
      else sz = 11'd1024;
      r = $urandom_range(99);
      if (r < 80 && cnt > 0) raw = m_offset + 32'($urandom_range(0, cnt - 1));
      else if (r < 90) raw = $urandom;
      else raw = m_offset + cnt + 32'($urandom_range(0, 3));
      pend_add(item($urandom_range(99) < 6, raw, sz));
    end
  endtask

  initial begin
    m_cap = 25'd65536;
    m_split = 1;
    m_offset = 0;
    m_count = 1;
    m_tuples = 0;
    m_bytes = 0;
    for (int p = 0; p < NPART; p++) begin
      m_fill[p] = 0;
      m_open[p] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    tx_idle = 19;
    rx_idle = 47;
    setup(64, 1, 10, 4);
    pend_add(item(0, 10, 0));
    pend_add(item(0, 10, 1));
    pend_add(item(0, 10, 63));
    pend_add(item(0, 10, 5));
    pend_add(item(0, 11, 64));
    pend_add(item(0, 11, 1024));
    pend_add(item(0, 12, 1025));
    pend_add(item(0, 12, 2047));
    pend_add(item(0, 13, 200));
    pend_add(item(0, 14, 5));
    pend_add(item(0, 9, 5));
    pend_add(item(0, 32'hFFFFFFFF, 7));
    pend_add(item(1, 32'hFFFFFFFF, 11'h7FF));
    pend_add(item(1, 0, 0));
    pend_add(item(0, 13, 0));
    add_random(35);
    drain();
    add_random(35);
    drain();

    setup(1000, 0, 32'hFFFFFFF0, 32);
    pend_add(item(0, 32'hFFFFFFF0, 900));
    pend_add(item(0, 32'hFFFFFFF1, 1000));
    pend_add(item(0, 32'hFFFFFFF1, 1001));
    add_random(80);
    drain();

    tx_idle = 47;
    rx_idle = 19;
    // lowered capacity leaves overfull buffers open
    setup(0, 0, 32'hFFFFFFF0, 40);
    add_random(80);
    drain();
    setup(32'h1FFFFFF, 1, 32'hFFFFFFFF, 0);
    add_random(30);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    setup(32'h1000000, 1, 5, 32);
    add_random(80);
    drain();
    setup(200, 1, 3, 7);
    add_random(100);
    drain();

    if (errs == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
